FILE: sv/mrwr_pkg.sv
// Shared types and constants of the Miller-Rabin witness round unit.
`default_nettype none
package mrwr_pkg;

  localparam int CAND_W      = 30;
  localparam int WIT_W       = 30;
  localparam int VERDICT_W   = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam verdict_t VERDICT_PRIME     = 2'd0;
  localparam verdict_t VERDICT_COMPOSITE = 2'd1;
  localparam verdict_t VERDICT_INVALID   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ZCHK,
    ST_SPLIT,
    ST_POW,
    ST_MUL,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MK_RES,
    MK_BASE,
    MK_SQX
  } mul_kind_t;

  typedef struct packed {
    logic add_en;
    logic dbl_cin;
  } step_ctl_t;

endpackage : mrwr_pkg
`default_nettype wire

FILE: sv/miller_rabin_witness_round_unit.sv
// Top level: sequencer, operand registers and result register of one witness round.
// One transaction carries a candidate n and a witness a and yields one verdict
// (0 probably prime, 1 composite, 2 candidate below 3). The block takes one
// transaction at a time: in_tready is high only while idle, and a finished verdict
// waits in the output register while the next transaction is taken. A transaction
// first reduces a mod n and checks it for zero, then splits n-1 into d * 2^s.
// Each modular product is one dispatch step, one step per multiplier bit and one
// step to finish. There are up to 2*bitlen(d) - 1 products for a^d and up to s
// for the final squarings. Small candidates finish sooner, and a witness that is
// zero mod n skips the products. A candidate below 3 goes straight to the result.
// The pace is set by the single shared modular step unit, which handles one
// multiplier bit per cycle.
`default_nettype none
module miller_rabin_witness_round_unit #(
  parameter int MOD_BITS = 30
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [29:0] candidate, [59:30] witness, [63:60] zero
  input  wire logic [mrwr_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [1:0] verdict, [7:2] zero
  output logic      [mrwr_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import mrwr_pkg::*;

  localparam int W     = MOD_BITS;
  localparam int CNT_W = $clog2(MOD_BITS);

  state_t         state_r, state_nxt;
  mul_kind_t      kind_r, kind_nxt;
  logic [W-1:0]   n_r, n_nxt;
  logic [W-1:0]   a_r, a_nxt;
  logic [W-1:0]   y_r, y_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   mx_r, mx_nxt;
  logic [W-1:0]   base_r, base_nxt;
  logic [W-1:0]   res_r, res_nxt;
  logic [W-1:0]   e_r, e_nxt;
  logic [CNT_W-1:0] s_r, s_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  verdict_t       verdict_r, verdict_nxt;
  verdict_t       out_verdict_r, out_verdict_nxt;
  logic           out_tvalid_r, out_tvalid_nxt;

  logic [W-1:0]   n_in;
  logic [W-1:0]   a_in;
  logic [W-1:0]   n_m1;
  logic [W-1:0]   acc_step;
  logic [W-1:0]   y_step;
  step_ctl_t      step_ctl;

  assign n_in = W'(in_tdata[CAND_W-1:0]);
  assign a_in = W'(in_tdata[CAND_W+WIT_W-1:CAND_W]);
  assign n_m1 = n_r - W'(1);

  assign step_ctl.add_en  = (state_r == ST_MUL) && mx_r[0];
  assign step_ctl.dbl_cin = (state_r == ST_REDUCE) && a_r[W-1];

  mrwr_mod_step #(
    .MOD_BITS(MOD_BITS)
  ) u_step (
    .n      (n_r),
    .acc    (acc_r),
    .y      (y_r),
    .ctl    (step_ctl),
    .acc_out(acc_step),
    .y_out  (y_step)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-VERDICT_W){1'b0}}, out_verdict_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    n_r           <= n_nxt;
    a_r           <= a_nxt;
    y_r           <= y_nxt;
    acc_r         <= acc_nxt;
    mx_r          <= mx_nxt;
    base_r        <= base_nxt;
    res_r         <= res_nxt;
    e_r           <= e_nxt;
    s_r           <= s_nxt;
    cnt_r         <= cnt_nxt;
    verdict_r     <= verdict_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    n_nxt           = n_r;
    a_nxt           = a_r;
    y_nxt           = y_r;
    acc_nxt         = acc_r;
    mx_nxt          = mx_r;
    base_nxt        = base_r;
    res_nxt         = res_r;
    e_nxt           = e_r;
    s_nxt           = s_r;
    cnt_nxt         = cnt_r;
    verdict_nxt     = verdict_r;
    out_verdict_nxt = out_verdict_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt   = n_in;
          a_nxt   = a_in;
          y_nxt   = '0;
          cnt_nxt = CNT_W'(W - 1);
          if (n_in < W'(3)) begin
            verdict_nxt = VERDICT_INVALID;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        y_nxt   = y_step;
        a_nxt   = a_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_ZCHK;
        end
      end
      ST_ZCHK: begin
        if (y_r == '0) begin
          verdict_nxt = VERDICT_PRIME;
          state_nxt   = ST_DONE;
        end else begin
          base_nxt  = y_r;
          e_nxt     = n_m1;
          s_nxt     = '0;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (!e_r[0]) begin
          e_nxt = e_r >> 1;
          s_nxt = s_r + CNT_W'(1);
        end else begin
          res_nxt   = W'(1);
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        acc_nxt = '0;
        if (e_r == '0) begin
          if (res_r == W'(1)) begin
            verdict_nxt = VERDICT_PRIME;
            state_nxt   = ST_DONE;
          end else begin
            state_nxt = ST_ROUND;
          end
        end else if (e_r[0]) begin
          mx_nxt    = res_r;
          y_nxt     = base_r;
          kind_nxt  = MK_RES;
          state_nxt = ST_MUL;
        end else begin
          mx_nxt    = base_r;
          y_nxt     = base_r;
          kind_nxt  = MK_BASE;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mx_r == '0) begin
          unique case (kind_r)
            MK_RES: begin
              res_nxt   = acc_r;
              e_nxt     = {e_r[W-1:1], 1'b0};
              state_nxt = ST_POW;
            end
            MK_BASE: begin
              base_nxt  = acc_r;
              e_nxt     = e_r >> 1;
              state_nxt = ST_POW;
            end
            MK_SQX: begin
              res_nxt   = acc_r;
              state_nxt = ST_ROUND;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end else begin
          acc_nxt = acc_step;
          y_nxt   = y_step;
          mx_nxt  = mx_r >> 1;
        end
      end
      ST_ROUND: begin
        if (s_r == '0) begin
          verdict_nxt = VERDICT_COMPOSITE;
          state_nxt   = ST_DONE;
        end else if (res_r == n_m1) begin
          verdict_nxt = VERDICT_PRIME;
          state_nxt   = ST_DONE;
        end else begin
          s_nxt     = s_r - CNT_W'(1);
          mx_nxt    = res_r;
          y_nxt     = res_r;
          acc_nxt   = '0;
          kind_nxt  = MK_SQX;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_verdict_nxt = verdict_r;
          out_tvalid_nxt  = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule : miller_rabin_witness_round_unit
`default_nettype wire

FILE: sv/mrwr_mod_step.sv
// Shared modular step unit: conditional acc + y and 2y + cin, both mod n.
`default_nettype none
module mrwr_mod_step #(
  parameter int MOD_BITS = 30
) (
  input  wire logic [MOD_BITS-1:0] n,
  input  wire logic [MOD_BITS-1:0] acc,
  input  wire logic [MOD_BITS-1:0] y,
  input  wire mrwr_pkg::step_ctl_t ctl,
  output logic      [MOD_BITS-1:0] acc_out,
  output logic      [MOD_BITS-1:0] y_out
);
  import mrwr_pkg::*;

  logic [MOD_BITS:0] sum_acc;
  logic [MOD_BITS:0] sum_dbl;
  logic [MOD_BITS:0] n_ext;

  assign n_ext   = {1'b0, n};
  assign sum_acc = {1'b0, acc} + {1'b0, y};
  assign sum_dbl = {1'b0, y} + {1'b0, y} + {{MOD_BITS{1'b0}}, ctl.dbl_cin};

  always_comb begin
    if (!ctl.add_en) begin
      acc_out = acc;
    end else if (sum_acc >= n_ext) begin
      acc_out = MOD_BITS'(sum_acc - n_ext);
    end else begin
      acc_out = MOD_BITS'(sum_acc);
    end
    if (sum_dbl >= n_ext) begin
      y_out = MOD_BITS'(sum_dbl - n_ext);
    end else begin
      y_out = MOD_BITS'(sum_dbl);
    end
  end

endmodule : mrwr_mod_step
`default_nettype wire

FILE: sv/mrwr_checker.sv
// Port-level checker for the witness round unit, with its bind.
`default_nettype none
module mrwr_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [mrwr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mrwr_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_verdict_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:VERDICT_W] == '0) &&
                   (out_tdata[VERDICT_W-1:0] <= VERDICT_INVALID))
    else $error("illegal verdict code");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

endmodule : mrwr_checker

bind miller_rabin_witness_round_unit mrwr_checker u_mrwr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
`default_nettype wire
